// ===== design/mpsc_pkg.sv =====
package mpsc_pkg;

  localparam int LANES      = 4;
  localparam int DATA_W     = 32;
  localparam int POS_W      = $clog2(2 * LANES);
  localparam int CNT_W      = $clog2(LANES);
  localparam int SLOT_W     = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  // One group of pairs; lane j sits in bits [j*DATA_W +: DATA_W].
  typedef struct packed {
    logic [LANES*DATA_W-1:0] index;
    logic [LANES*DATA_W-1:0] value;
    logic [LANES-1:0]        keep_mask;
    logic                    last_group;
  } grp_req_t;

  typedef struct packed {
    logic [LANES*DATA_W-1:0] index;
    logic [LANES*DATA_W-1:0] value;
    logic [SLOT_W-1:0]       slots_valid;
    logic                    end_of_stream;
    logic [DATA_W-1:0]       total_kept;
  } grp_res_t;

  // Results produced by one accepted request: none, a full one, a closing one, or both.
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

// ===== design/mpsc_lane.sv =====
module mpsc_lane #(
  parameter int LANE_ID = 0
) (
  input  logic [mpsc_pkg::LANES-1:0] keep_mask,
  input  logic [mpsc_pkg::CNT_W-1:0] carry_count,
  output logic                       keep,
  output logic [mpsc_pkg::POS_W-1:0] pos
);
  import mpsc_pkg::*;

  logic [POS_W-1:0] below;

  // Kept lanes ahead of this one push it further back in the packed order.
  always_comb begin
    below = '0;
    for (int j = 0; j < LANES; j++) begin
      if (j < LANE_ID) begin
        below = below + POS_W'(keep_mask[j]);
      end
    end
  end

  assign keep = keep_mask[LANE_ID];
  assign pos  = POS_W'(carry_count) + below;

endmodule

// ===== design/mpsc_merge.sv =====
module mpsc_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  mpsc_pkg::grp_req_t  req,
  output mpsc_pkg::grp_res_t  res_a,
  output mpsc_pkg::grp_res_t  res_b,
  output mpsc_pkg::push_t     push
);
  import mpsc_pkg::*;

  logic [DATA_W-1:0] carry_index [LANES-1];
  logic [DATA_W-1:0] carry_value [LANES-1];
  logic [CNT_W-1:0]  carry_count;
  logic [DATA_W-1:0] kept_total;

  logic [CNT_W-1:0]  carry_count_next;
  logic [DATA_W-1:0] kept_total_next;

  logic             lane_keep [LANES];
  logic [POS_W-1:0] lane_pos  [LANES];

  logic [DATA_W-1:0] slot_idx [2*LANES];
  logic [DATA_W-1:0] slot_val [2*LANES];

  logic [POS_W-1:0]  kept;
  logic [POS_W-1:0]  n;
  logic              full;
  logic [CNT_W-1:0]  rest;
  logic [DATA_W-1:0] sum;

  genvar g;
  for (g = 0; g < LANES; g++) begin : g_lane
    mpsc_lane #(.LANE_ID(g)) u_lane (
      .keep_mask   (req.keep_mask),
      .carry_count (carry_count),
      .keep        (lane_keep[g]),
      .pos         (lane_pos[g])
    );
  end

  // Each packed slot takes either a carried pair or the one kept lane aimed at it.
  for (g = 0; g < 2 * LANES; g++) begin : g_slot
    logic [DATA_W-1:0] c_idx;
    logic [DATA_W-1:0] c_val;
    if (g < LANES - 1) begin : g_carry
      assign c_idx = (CNT_W'(g) < carry_count) ? carry_index[g] : '0;
      assign c_val = (CNT_W'(g) < carry_count) ? carry_value[g] : '0;
    end else begin : g_nocarry
      assign c_idx = '0;
      assign c_val = '0;
    end
    always_comb begin
      slot_idx[g] = c_idx;
      slot_val[g] = c_val;
      for (int j = 0; j < LANES; j++) begin
        if (lane_keep[j] && lane_pos[j] == POS_W'(g)) begin
          slot_idx[g] = slot_idx[g] | req.index[j*DATA_W +: DATA_W];
          slot_val[g] = slot_val[g] | req.value[j*DATA_W +: DATA_W];
        end
      end
    end
  end

  always_comb begin
    kept = '0;
    for (int j = 0; j < LANES; j++) begin
      kept = kept + POS_W'(req.keep_mask[j]);
    end
  end

  assign n    = POS_W'(carry_count) + kept;
  assign full = n >= POS_W'(LANES);
  assign rest = full ? CNT_W'(n - POS_W'(LANES)) : CNT_W'(n);
  assign sum  = kept_total + DATA_W'(kept);

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      res_a.index[j*DATA_W +: DATA_W] = slot_idx[j];
      res_a.value[j*DATA_W +: DATA_W] = slot_val[j];
      if (CNT_W'(j) < rest && j < LANES - 1) begin
        res_b.index[j*DATA_W +: DATA_W] = full ? slot_idx[LANES+j] : slot_idx[j];
        res_b.value[j*DATA_W +: DATA_W] = full ? slot_val[LANES+j] : slot_val[j];
      end else begin
        res_b.index[j*DATA_W +: DATA_W] = '0;
        res_b.value[j*DATA_W +: DATA_W] = '0;
      end
    end
    res_a.slots_valid   = SLOT_W'(LANES);
    res_a.end_of_stream = req.last_group && n == POS_W'(LANES);
    res_a.total_kept    = sum;
    res_b.slots_valid   = SLOT_W'(rest);
    res_b.end_of_stream = 1'b1;
    res_b.total_kept    = sum;
  end

  assign push.push_a = accept && full;
  assign push.push_b = accept && req.last_group && (rest != '0 || !full);

  assign carry_count_next = req.last_group ? '0 : rest;
  assign kept_total_next  = req.last_group ? '0 : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_count <= '0;
      kept_total  <= '0;
    end else if (accept) begin
      carry_count <= carry_count_next;
      kept_total  <= kept_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < LANES - 1; j++) begin
        carry_index[j] <= full ? slot_idx[LANES+j] : slot_idx[j];
        carry_value[j] <= full ? slot_val[LANES+j] : slot_val[j];
      end
    end
  end

endmodule

// ===== design/mpsc_outq.sv =====
module mpsc_outq (
  input  logic                clk,
  input  logic                rst,
  input  mpsc_pkg::push_t     push,
  input  mpsc_pkg::grp_res_t  res_a,
  input  mpsc_pkg::grp_res_t  res_b,
  output logic                room,
  output logic                dst_valid,
  input  logic                dst_stall,
  output mpsc_pkg::grp_res_t  dst_data
);
  import mpsc_pkg::*;

  grp_res_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  grp_res_t          first_res;
  logic [1:0]        npush;
  logic              pop;

  assign first_res = push.push_a ? res_a : res_b;
  assign npush     = 2'(push.push_a) + 2'(push.push_b);
  assign pop       = dst_valid && !dst_stall;

  // A request may add two results, so new requests need two free entries.
  assign room      = fill <= FILL_W'(FIFO_DEPTH - 2);
  assign dst_valid = fill != '0;
  assign dst_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push_a || push.push_b) begin
      mem[wr_ptr] <= first_res;
    end
    if (push.push_a && push.push_b) begin
      mem[wr_ptr + PTR_W'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(npush);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      fill   <= fill + FILL_W'(npush) - FILL_W'(pop);
    end
  end

endmodule

// ===== design/masked_pair_stream_compactor.sv =====
// Masked pair stream compactor.
// The source channel (src_valid, src_stall, src_data) carries one request per
// group: four (index, value) pairs, a keep mask and a last-group flag. The
// destination channel (dst_valid, dst_stall, dst_data) carries packed results
// of four slots with the count of leading valid slots, an end-of-stream flag
// and the running total of kept pairs.
// Each request is compacted in the cycle it is accepted: four lane units place
// their pairs behind the carried ones and a merge stage forms the results and
// the new carry. Results are written into the output queue on acceptance.
// Throughput is one request per cycle while there is room. A last group may
// yield two results; they leave the four-entry output queue one per cycle
// unless stalled; the source sees stall once fewer than two entries are free.
// When the destination stalls, the head result holds steady and the queue
// fills; the source is stalled once it can no longer take two more results.
// Synchronous reset empties the queue and clears the carry count and total, so
// the first request after reset opens a new stream.
module masked_pair_stream_compactor (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  mpsc_pkg::grp_req_t  src_data,
  output logic                dst_valid,
  input  logic                dst_stall,
  output mpsc_pkg::grp_res_t  dst_data
);
  import mpsc_pkg::*;

  grp_res_t res_a;
  grp_res_t res_b;
  push_t    push;
  logic     room;
  logic     accept;

  // The stall depends only on queue fill, never on the source's valid.
  assign src_stall = !room;
  assign accept    = src_valid && room;

  mpsc_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (src_data),
    .res_a  (res_a),
    .res_b  (res_b),
    .push   (push)
  );

  mpsc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (room),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule

// ===== design/mpsc_checker.sv =====
module mpsc_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input mpsc_pkg::grp_req_t  src_data,
  input logic                dst_valid,
  input logic                dst_stall,
  input mpsc_pkg::grp_res_t  dst_data
);
  import mpsc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("stalled result changed or dropped");

  a_full: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_data.end_of_stream |-> dst_data.slots_valid == SLOT_W'(LANES))
    else $error("result inside a stream is not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.slots_valid == '0 |-> dst_data.index == '0 && dst_data.value == '0)
    else $error("empty result carries nonzero slots");

  a_reset: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result present after reset");

endmodule

bind masked_pair_stream_compactor mpsc_checker u_chk (.*);

// ===== verif/tb_masked_pair_stream_compactor.sv =====
// Checks the compactor against its own model of the packing rules.
// The harness runs a short directed sequence and then long runs of random
// streams, each of which ends with a last group, in three phases. Both channels
// idle at random in the first two phases; the third runs with no idling.
module tb_masked_pair_stream_compactor;
  timeunit 1ns;
  timeprecision 1ps;

  import mpsc_pkg::*;

  // Watchdog limit, counted in cycles with no request and no result accepted.
  localparam int QUIET_LIMIT = 4000;
  // Results are queued inside the block, so a short drain is plenty.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 610;

  // Tracks the carried pairs and the stream total exactly as the block should.
  // Every accepted request is folded in, and the results it must cause are
  // queued in order.
  class packed_pair_tracker;
    logic [DATA_W-1:0] held_index [LANES-1];
    logic [DATA_W-1:0] held_value [LANES-1];
    int                held_count;
    logic [DATA_W-1:0] stream_total;
    logic [DATA_W-1:0] work_index [2*LANES];
    logic [DATA_W-1:0] work_value [2*LANES];
    grp_res_t          due_groups [$];
    int                fails;

    function new();
      held_count   = 0;
      stream_total = '0;
      fails        = 0;
    endfunction

    function int pending();
      return due_groups.size();
    endfunction

    // Builds one result from count pairs starting at first. Unused slots are zero.
    function void queue_result(int first, int count, bit eos);
      grp_res_t r;
      r = '0;
      for (int j = 0; j < count; j++) begin
        r.index[j*DATA_W +: DATA_W] = work_index[first+j];
        r.value[j*DATA_W +: DATA_W] = work_value[first+j];
      end
      r.slots_valid   = SLOT_W'(count);
      r.end_of_stream = eos;
      r.total_kept    = stream_total;
      due_groups.push_back(r);
    endfunction

    function void absorb_group(grp_req_t g);
      int n;
      int first;
      int rest;
      bit produced;
      n = held_count;
      for (int j = 0; j < n; j++) begin
        work_index[j] = held_index[j];
        work_value[j] = held_value[j];
      end
      for (int j = 0; j < LANES; j++) begin
        if (g.keep_mask[j]) begin
          work_index[n] = g.index[j*DATA_W +: DATA_W];
          work_value[n] = g.value[j*DATA_W +: DATA_W];
          n++;
          stream_total = stream_total + 1'b1;
        end
      end
      first    = 0;
      rest     = n;
      produced = 1'b0;
      if (rest >= LANES) begin
        queue_result(0, LANES, g.last_group && rest == LANES);
        first    = LANES;
        rest     = rest - LANES;
        produced = 1'b1;
      end
      if (g.last_group) begin
        if (rest > 0 || !produced) begin
          queue_result(first, rest, 1'b1);
        end
        held_count   = 0;
        stream_total = '0;
      end else begin
        for (int j = 0; j < rest; j++) begin
          held_index[j] = work_index[first+j];
          held_value[j] = work_value[first+j];
        end
        held_count = rest;
      end
    endfunction

    function void report_field(string field, logic [LANES*DATA_W-1:0] want,
                               logic [LANES*DATA_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
        fails++;
      end
    endfunction

    function void match_packed_result(grp_res_t got);
      grp_res_t want;
      if (due_groups.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        fails++;
        return;
      end
      want = due_groups.pop_front();
      report_field("index", want.index, got.index);
      report_field("value", want.value, got.value);
      report_field("slots_valid", want.slots_valid, got.slots_valid);
      report_field("end_of_stream", want.end_of_stream, got.end_of_stream);
      report_field("total_kept", want.total_kept, got.total_kept);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_stall;
  grp_req_t src_data = '0;
  logic     dst_valid;
  logic     dst_stall = 1'b0;
  grp_res_t dst_data;

  // Idle rates in percent, changed between phases by the stimulus process.
  int src_idle_pct = 18;
  int dst_stall_pct = 68;
  int quiet_cycles = 0;

  packed_pair_tracker board;

  masked_pair_stream_compactor u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

  always #4 clk = ~clk;

  // The receiver decides at every falling edge whether to stall the next edge.
  always @(negedge clk) begin
    dst_stall <= ($urandom_range(0, 99) < dst_stall_pct);
  end

  // Both handshakes are observed at the rising edge. A request is folded into
  // the tracker before any result of the same edge is checked; a result can
  // never belong to a request accepted at the same edge, so the order is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) begin
        board.absorb_group(src_data);
      end
      if (dst_valid && !dst_stall) begin
        board.match_packed_result(dst_data);
      end
      if ((src_valid && !src_stall) || (dst_valid && !dst_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: watchdog expired with %0d results outstanding",
                   $time, board.pending());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  // Data words lean toward the extremes now and then so that the all-zero and
  // all-one patterns show up in every lane.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic grp_req_t random_group(logic [LANES-1:0] mask, logic last);
    grp_req_t g;
    for (int j = 0; j < LANES; j++) begin
      g.index[j*DATA_W +: DATA_W] = pick_word();
      g.value[j*DATA_W +: DATA_W] = pick_word();
    end
    g.keep_mask  = mask;
    g.last_group = last;
    return g;
  endfunction

  // Presents one request at a falling edge, possibly after some idle cycles,
  // and holds it steady until the block takes it.
  task automatic send_group(input grp_req_t g);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(negedge clk);
    end
    src_valid <= 1'b1;
    src_data  <= g;
    @(posedge clk);
    while (src_stall) begin
      @(posedge clk);
    end
  endtask

  // The sender goes quiet until every outstanding result has been delivered.
  task automatic hold_until_drained();
    @(negedge clk);
    src_valid <= 1'b0;
    while (board.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  // Random streams of one to twelve groups, each closed by a last group. Masks
  // favor the empty and the full case a little, since they decide the edges of
  // the carry logic.
  task automatic run_random_streams(input int items);
    int sent;
    int len;
    logic [LANES-1:0] mask;
    sent = 0;
    while (sent < items) begin
      len = $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0: mask = '0;
          1: mask = '1;
          default: mask = LANES'($urandom);
        endcase
        send_group(random_group(mask, k == len - 1));
        sent++;
      end
    end
  endtask

  initial begin
    grp_req_t g;
    board = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An empty last group right after reset must still report a zero total.
    send_group(random_group('0, 1'b0) | grp_req_t'(1));
    // A full group of all-one indices and zero values, mid stream.
    g = '0;
    g.index = '1;
    g.keep_mask = '1;
    send_group(g);
    // A full group that closes the stream exactly: one result, marked final.
    g = '0;
    g.value = '1;
    g.keep_mask = '1;
    g.last_group = 1'b1;
    send_group(g);
    // Every nonzero mask in turn, at whatever carry depth the groups before leave.
    for (int m = 1; m < (1 << LANES); m++) begin
      send_group(random_group(LANES'(m), 1'b0));
    end
    // Closing with carried pairs and a full mask gives two results.
    send_group(random_group(4'h3, 1'b0));
    send_group(random_group('1, 1'b1));
    // Three carried plus three kept: a full result, then two left over.
    send_group(random_group(4'h7, 1'b0));
    send_group(random_group(4'hE, 1'b1));
    // A group that keeps nothing, then an empty close of the stream.
    send_group(random_group('0, 1'b0));
    send_group(random_group('0, 1'b1));

    run_random_streams(RANDOM_PER_PHASE);

    // Second phase: the sender is mostly quiet and the receiver rarely stalls.
    src_idle_pct  = 68;
    dst_stall_pct = 18;
    run_random_streams(RANDOM_PER_PHASE / 2);
    hold_until_drained();
    run_random_streams(RANDOM_PER_PHASE / 2);

    // Last phase runs at full rate on both sides.
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    run_random_streams(RANDOM_PER_PHASE);

    @(negedge clk);
    src_valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mpsc_pkg.sv
design/mpsc_lane.sv
design/mpsc_merge.sv
design/mpsc_outq.sv
design/masked_pair_stream_compactor.sv
design/mpsc_checker.sv
verif/tb_masked_pair_stream_compactor.sv
